/* sv/ebdc_pkg.sv */
// shared types, constants and helper function of the balanced drive controller
package ebdc_pkg;

	localparam int COUNT_BITS_DEF = 16;
	localparam int TARGET_W       = 15;
	localparam int SPEED_W        = 8;
	localparam int PWM_W          = 8;
	localparam int DUTY_W         = 9;
	localparam int LINES_W        = 4;
	localparam int MODE_W         = 4;
	localparam int GAP_W          = 16;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 8;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	localparam logic [2:0] MOVE_STRAIGHT = 3'd1;
	localparam logic [2:0] MOVE_BACK     = 3'd2;
	localparam logic [2:0] MOVE_ROT_CW   = 3'd3;
	localparam logic [2:0] MOVE_ROT_CC   = 3'd4;

	localparam logic [LINES_W-1:0] LINES_STRAIGHT = 4'h9;
	localparam logic [LINES_W-1:0] LINES_ROT_CW   = 4'hA;
	localparam logic [LINES_W-1:0] LINES_ROT_CC   = 4'h5;
	localparam logic [LINES_W-1:0] LINES_DEFAULT  = 4'h6;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PWM = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PWM = 1'd1;

	localparam logic [PWM_W-1:0] MAX_PWM_RST = 8'd240;
	localparam logic [PWM_W-1:0] MIN_PWM_RST = 8'd0;

	localparam logic signed [MODE_W-1:0] BAND_ZERO = 4'sd0;
	localparam logic signed [MODE_W-1:0] BAND_P1   = 4'sd1;
	localparam logic signed [MODE_W-1:0] BAND_P2   = 4'sd2;
	localparam logic signed [MODE_W-1:0] BAND_P4   = 4'sd4;
	localparam logic signed [MODE_W-1:0] BAND_N1   = -4'sd1;
	localparam logic signed [MODE_W-1:0] BAND_N2   = -4'sd2;
	localparam logic signed [MODE_W-1:0] BAND_N3   = -4'sd3;
	localparam logic signed [MODE_W-1:0] BAND_N4   = -4'sd4;

	localparam int GAP_BAND_1  = 15;
	localparam int GAP_BAND_2  = 50;
	localparam int GAP_BAND_N3 = 35;
	localparam int BOOST_LIMIT = 70;
	localparam int RIGHT_OFFS  = 3;

	typedef struct packed {
		logic                  kind;
		logic [TARGET_W-1:0]   target_pulses;
		logic [SPEED_W-1:0]    base_speed;
		logic [2:0]            move_type;
		logic                  left_pulse;
		logic                  right_pulse;
	} item_t;

	typedef struct packed {
		logic [PWM_W-1:0]          left_pwm;
		logic [PWM_W-1:0]          right_pwm;
		logic [LINES_W-1:0]        drive_lines;
		logic [LINES_W-1:0]        brake_lines;
		logic                      busy_res;
		logic                      done_res;
		logic signed [MODE_W-1:0]  band_mode;
		logic signed [GAP_W-1:0]   count_gap;
	} result_t;

	typedef struct packed {
		logic [PWM_W-1:0] max_pwm;
		logic [PWM_W-1:0] min_pwm;
	} cfg_t;

	// x / 10 by reciprocal, exact for 8-bit x
	function automatic logic [SPEED_W-1:0] div10(input logic [SPEED_W-1:0] x);
		logic [SPEED_W+11:0] prod;
		prod = {12'd0, x} * 20'd205;
		return prod[SPEED_W+10:11];
	endfunction

endpackage

/* sv/ebdc_in_if.sv */
// input item channel: valid, ready and item fields
interface ebdc_in_if;
	import ebdc_pkg::*;

	logic                valid;
	logic                ready;
	logic                kind;
	logic [TARGET_W-1:0] target_pulses;
	logic [SPEED_W-1:0]  base_speed;
	logic [2:0]          move_type;
	logic                left_pulse;
	logic                right_pulse;

	modport source (
		output valid, kind, target_pulses, base_speed, move_type, left_pulse, right_pulse,
		input  ready
	);
	modport sink (
		input  valid, kind, target_pulses, base_speed, move_type, left_pulse, right_pulse,
		output ready
	);
endinterface

/* sv/ebdc_out_if.sv */
// result channel: valid, ready and result fields
interface ebdc_out_if;
	import ebdc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [PWM_W-1:0]         left_pwm;
	logic [PWM_W-1:0]         right_pwm;
	logic [LINES_W-1:0]       drive_lines;
	logic [LINES_W-1:0]       brake_lines;
	logic                     busy_res;
	logic                     done_res;
	logic signed [MODE_W-1:0] band_mode;
	logic signed [GAP_W-1:0]  count_gap;

	modport source (
		output valid, left_pwm, right_pwm, drive_lines, brake_lines, busy_res, done_res,
			band_mode, count_gap,
		input  ready
	);
	modport sink (
		input  valid, left_pwm, right_pwm, drive_lines, brake_lines, busy_res, done_res,
			band_mode, count_gap,
		output ready
	);
endinterface

/* sv/ebdc_core.sv */
// move state registers and the single-pass start and tick update
module ebdc_core #(
	parameter int COUNT_BITS = ebdc_pkg::COUNT_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ebdc_pkg::item_t  item,
	input  ebdc_pkg::cfg_t   cfg,
	output ebdc_pkg::result_t res
);
	import ebdc_pkg::*;

	localparam int CW = ((COUNT_BITS > TARGET_W) ? COUNT_BITS : TARGET_W) + 2;
	localparam int GW = COUNT_BITS + 1;
	localparam int WW = GW + GAP_W + 1;

	localparam logic signed [GW-1:0] T_B1  = GW'(GAP_BAND_1);
	localparam logic signed [GW-1:0] T_B2  = GW'(GAP_BAND_2);
	localparam logic signed [GW-1:0] T_BN3 = GW'(GAP_BAND_N3);
	localparam logic signed [WW-1:0] GAP_HI = WW'(32767);
	localparam logic signed [WW-1:0] GAP_LO = -WW'(32768);

	logic [COUNT_BITS-1:0]    lcnt_q, rcnt_q, lcnt_d, rcnt_d, lcnt_inc, rcnt_inc;
	logic [TARGET_W-1:0]      target_q, target_d;
	logic [PWM_W-1:0]         lduty_q, lduty_d;
	logic [DUTY_W-1:0]        rduty_q, rduty_d;
	logic                     slow_q, slow_d;
	logic [LINES_W-1:0]       lines_q, lines_d, lines_sel;
	logic                     run_q, run_d;
	logic signed [MODE_W-1:0] mode_q, mode_d;
	logic                     done;

	logic [CW-1:0]            l_ext, r_ext, t_ext;
	logic signed [GW-1:0]     diff;
	logic signed [WW-1:0]     gap_w;
	logic signed [MODE_W-1:0] band, dstep;
	logic signed [DUTY_W:0]   rsum, rclamp;
	logic [SPEED_W-1:0]       boost;

	assign lcnt_inc = (item.left_pulse && lcnt_q != '1) ? lcnt_q + 1'b1 : lcnt_q;
	assign rcnt_inc = (item.right_pulse && rcnt_q != '1) ? rcnt_q + 1'b1 : rcnt_q;
	assign l_ext = CW'(lcnt_inc);
	assign r_ext = CW'(rcnt_inc);
	assign t_ext = CW'(target_q);
	assign diff  = $signed({1'b0, lcnt_inc}) - $signed({1'b0, rcnt_inc});
	assign boost = (item.base_speed < SPEED_W'(BOOST_LIMIT)) ? div10(item.base_speed) : '0;

	always_comb begin
		unique case (item.move_type)
			MOVE_STRAIGHT: lines_sel = LINES_STRAIGHT;
			MOVE_ROT_CW:   lines_sel = LINES_ROT_CW;
			MOVE_ROT_CC:   lines_sel = LINES_ROT_CC;
			default:       lines_sel = LINES_DEFAULT;
		endcase
	end

	always_comb begin
		lcnt_d   = lcnt_q;
		rcnt_d   = rcnt_q;
		target_d = target_q;
		lduty_d  = lduty_q;
		rduty_d  = rduty_q;
		slow_d   = slow_q;
		lines_d  = lines_q;
		run_d    = run_q;
		mode_d   = mode_q;
		done     = 1'b0;
		band     = BAND_ZERO;
		dstep    = '0;
		rsum     = '0;
		rclamp   = '0;
		if (item.kind == KIND_START) begin
			lcnt_d   = '0;
			rcnt_d   = '0;
			target_d = item.target_pulses;
			slow_d   = 1'b0;
			mode_d   = BAND_ZERO;
			lduty_d  = item.base_speed;
			rduty_d  = DUTY_W'(item.base_speed) + DUTY_W'(RIGHT_OFFS) + DUTY_W'(boost);
			lines_d  = lines_sel;
			run_d    = 1'b1;
		end else if (run_q) begin
			lcnt_d = lcnt_inc;
			rcnt_d = rcnt_inc;
			if (l_ext >= t_ext && r_ext >= t_ext) begin
				done    = 1'b1;
				run_d   = 1'b0;
				lduty_d = cfg.max_pwm;
				rduty_d = DUTY_W'(cfg.max_pwm);
			end else begin
				if ({l_ext[CW-2:0], 1'b0} > t_ext && {r_ext[CW-2:0], 1'b0} > t_ext) begin
					if (lduty_q != '0)
						lduty_d = lduty_q - 1'b1;
					slow_d = 1'b1;
				end
				if (diff > T_B2) begin
					band = BAND_P4; dstep = 4'sd4;
				end else if (diff > T_B1) begin
					band = BAND_P2; dstep = 4'sd2;
				end else if (diff > 0) begin
					band = BAND_P1; dstep = 4'sd1;
				end else if (diff < -T_B2) begin
					band = BAND_N4; dstep = slow_d ? -4'sd4 : -4'sd5;
				end else if (diff < -T_BN3) begin
					band = BAND_N3; dstep = slow_d ? -4'sd3 : -4'sd4;
				end else if (diff < -T_B1) begin
					band = BAND_N2; dstep = slow_d ? -4'sd1 : -4'sd2;
				end else if (diff < 0) begin
					band = BAND_N1; dstep = slow_d ? 4'sd0 : -4'sd1;
				end
				mode_d = band;
				if (diff != 0) begin
					rsum   = $signed({1'b0, rduty_q}) + (DUTY_W+1)'(dstep);
					rclamp = rsum;
					if (rclamp < $signed({2'b00, cfg.min_pwm}))
						rclamp = $signed({2'b00, cfg.min_pwm});
					if (rclamp > $signed({2'b00, cfg.max_pwm}))
						rclamp = $signed({2'b00, cfg.max_pwm});
					rduty_d = rclamp[DUTY_W-1:0];
				end
			end
		end
	end

	// result fields from the updated state
	always_comb begin
		gap_w = WW'($signed({1'b0, lcnt_d}) - $signed({1'b0, rcnt_d}));
		if (gap_w > GAP_HI)
			gap_w = GAP_HI;
		else if (gap_w < GAP_LO)
			gap_w = GAP_LO;
		res.left_pwm    = lduty_d;
		res.right_pwm   = (rduty_d > DUTY_W'(255)) ? 8'hFF : rduty_d[PWM_W-1:0];
		res.drive_lines = lines_d;
		res.brake_lines = (lines_d != '0) ? ~lines_d : '0;
		res.busy_res    = run_d;
		res.done_res    = done;
		res.band_mode   = mode_d;
		res.count_gap   = gap_w[GAP_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q   <= '0;
			rcnt_q   <= '0;
			target_q <= '0;
			lduty_q  <= '0;
			rduty_q  <= '0;
			slow_q   <= 1'b0;
			lines_q  <= '0;
			run_q    <= 1'b0;
			mode_q   <= BAND_ZERO;
		end else if (step) begin
			lcnt_q   <= lcnt_d;
			rcnt_q   <= rcnt_d;
			target_q <= target_d;
			lduty_q  <= lduty_d;
			rduty_q  <= rduty_d;
			slow_q   <= slow_d;
			lines_q  <= lines_d;
			run_q    <= run_d;
			mode_q   <= mode_d;
		end
	end

endmodule

/* sv/encoder_balanced_drive_control.sv */
// top level: input register, configuration registers, core and result register
// an accepted item is held in the input register, and the core's result for it in the result register
// throughput: one item per cycle while results are taken, set by the single-pass update in the core
// while a result waits to be taken the input register takes one more item and holds
// reset clears all move state, the valid flags and loads the pwm limits (240, 0)
module encoder_balanced_drive_control #(
	parameter int COUNT_BITS = ebdc_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	ebdc_in_if.sink                          items,
	ebdc_out_if.source                       results,
	input  logic                             cfg_we,
	input  logic [ebdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ebdc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ebdc_pkg::*;

	logic    valid_s1, res_valid_q, advance, fire;
	item_t   item_s1;
	cfg_t    cfg_q;
	result_t res_c, res_q;

	assign advance     = !res_valid_q || results.ready;
	assign fire        = valid_s1 && advance;
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_pwm <= MAX_PWM_RST;
			cfg_q.min_pwm <= MIN_PWM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_PWM: cfg_q.max_pwm <= cfg_wdata[PWM_W-1:0];
				CFG_MIN_PWM: cfg_q.min_pwm <= cfg_wdata[PWM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (items.ready)
			valid_s1 <= items.valid;
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			item_s1.kind          <= items.kind;
			item_s1.target_pulses <= items.target_pulses;
			item_s1.base_speed    <= items.base_speed;
			item_s1.move_type     <= items.move_type;
			item_s1.left_pulse    <= items.left_pulse;
			item_s1.right_pulse   <= items.right_pulse;
		end
	end

	ebdc_core #(
		.COUNT_BITS(COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (fire),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (advance)
			res_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (fire)
			res_q <= res_c;
	end

	assign results.valid       = res_valid_q;
	assign results.left_pwm    = res_q.left_pwm;
	assign results.right_pwm   = res_q.right_pwm;
	assign results.drive_lines = res_q.drive_lines;
	assign results.brake_lines = res_q.brake_lines;
	assign results.busy_res    = res_q.busy_res;
	assign results.done_res    = res_q.done_res;
	assign results.band_mode   = res_q.band_mode;
	assign results.count_gap   = res_q.count_gap;

endmodule

/* bench/ebdc_checker.sv */
// checker: predicts each drive controller result from accepted items and compares transfers
module ebdc_checker #(
	parameter int COUNT_BITS = ebdc_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	ebdc_in_if                              items,
	ebdc_out_if                             results,
	input  logic                            cfg_we,
	input  logic [ebdc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ebdc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              fail_count,
	output int                              in_flight
);
	timeunit 1ns;
	timeprecision 1ps;
	import ebdc_pkg::*;

	logic [PWM_W-1:0]         max_lim = MAX_PWM_RST;
	logic [PWM_W-1:0]         min_lim = MIN_PWM_RST;
	logic [COUNT_BITS-1:0]    left_cnt;
	logic [COUNT_BITS-1:0]    right_cnt;
	logic [TARGET_W-1:0]      goal;
	logic [PWM_W-1:0]         left_duty;
	logic [DUTY_W-1:0]        right_duty;
	logic                     slowing;
	logic [LINES_W-1:0]       lines;
	logic                     moving;
	logic signed [MODE_W-1:0] band;

	result_t pwm_results_q[$];
	int      mism = 0;

	assign fail_count = mism;

	task automatic report(input string msg);
		if (mism < 40)
			$display("%0t ns: %s", $realtime, msg);
		mism++;
	endtask

	task automatic check_field(input string name, input longint got, input longint want);
		if (got != want)
			report($sformatf("%s mismatch: got %0d, want %0d", name, got, want));
	endtask

	function automatic result_t step_controller(input item_t it);
		result_t r;
		logic    done;
		longint  d;
		longint  nudge;
		longint  duty;
		longint  gap;
		done = 1'b0;
		if (it.kind == KIND_START) begin
			goal      = it.target_pulses;
			left_cnt  = '0;
			right_cnt = '0;
			slowing   = 1'b0;
			band      = BAND_ZERO;
			left_duty = it.base_speed;
			duty      = longint'(it.base_speed) + RIGHT_OFFS;
			if (it.base_speed < BOOST_LIMIT)
				duty += longint'(it.base_speed) / 10;
			right_duty = DUTY_W'(duty);
			case (it.move_type)
				MOVE_STRAIGHT: lines = LINES_STRAIGHT;
				MOVE_ROT_CW:   lines = LINES_ROT_CW;
				MOVE_ROT_CC:   lines = LINES_ROT_CC;
				default:       lines = LINES_DEFAULT;
			endcase
			moving = 1'b1;
		end else if (moving) begin
			if (it.left_pulse && left_cnt != {COUNT_BITS{1'b1}})
				left_cnt++;
			if (it.right_pulse && right_cnt != {COUNT_BITS{1'b1}})
				right_cnt++;
			if (left_cnt >= goal && right_cnt >= goal) begin
				moving     = 1'b0;
				left_duty  = max_lim;
				right_duty = DUTY_W'(max_lim);
				done       = 1'b1;
			end else begin
				if (2 * longint'(left_cnt) > longint'(goal) &&
				    2 * longint'(right_cnt) > longint'(goal)) begin
					if (left_duty != '0)
						left_duty--;
					slowing = 1'b1;
				end
				d = longint'(left_cnt) - longint'(right_cnt);
				nudge = 0;
				if (d == 0) begin
					band = BAND_ZERO;
				end else if (d > 0) begin
					if (d > GAP_BAND_2) begin
						band = BAND_P4;
						nudge = 4;
					end else if (d > GAP_BAND_1) begin
						band = BAND_P2;
						nudge = 2;
					end else begin
						band = BAND_P1;
						nudge = 1;
					end
				end else begin
					if (d < -GAP_BAND_2) begin
						band = BAND_N4;
						nudge = -(5 - longint'(slowing));
					end else if (d < -GAP_BAND_N3) begin
						band = BAND_N3;
						nudge = -(4 - longint'(slowing));
					end else if (d < -GAP_BAND_1) begin
						band = BAND_N2;
						nudge = -(2 - longint'(slowing));
					end else begin
						band = BAND_N1;
						nudge = -(1 - longint'(slowing));
					end
				end
				if (d != 0) begin
					duty = longint'(right_duty) + nudge;
					if (duty < longint'(min_lim))
						duty = longint'(min_lim);
					if (duty > longint'(max_lim))
						duty = longint'(max_lim);
					right_duty = DUTY_W'(duty);
				end
			end
		end
		gap = longint'(left_cnt) - longint'(right_cnt);
		if (gap > 32767)
			gap = 32767;
		if (gap < -32768)
			gap = -32768;
		r.left_pwm    = left_duty;
		r.right_pwm   = (right_duty > 9'd255) ? 8'd255 : right_duty[PWM_W-1:0];
		r.drive_lines = lines;
		r.brake_lines = (lines != '0) ? ~lines : '0;
		r.busy_res    = moving;
		r.done_res    = done;
		r.band_mode   = band;
		r.count_gap   = GAP_W'(gap);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		item_t   it;
		if (!arst_n) begin
			max_lim    = MAX_PWM_RST;
			min_lim    = MIN_PWM_RST;
			left_cnt   = '0;
			right_cnt  = '0;
			goal       = '0;
			left_duty  = '0;
			right_duty = '0;
			slowing    = 1'b0;
			lines      = '0;
			moving     = 1'b0;
			band       = BAND_ZERO;
			pwm_results_q.delete();
			in_flight <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_PWM: max_lim = cfg_wdata;
					CFG_MIN_PWM: min_lim = cfg_wdata;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				got.left_pwm    = results.left_pwm;
				got.right_pwm   = results.right_pwm;
				got.drive_lines = results.drive_lines;
				got.brake_lines = results.brake_lines;
				got.busy_res    = results.busy_res;
				got.done_res    = results.done_res;
				got.band_mode   = results.band_mode;
				got.count_gap   = results.count_gap;
				if (pwm_results_q.size() == 0) begin
					report("result transfer with nothing outstanding");
				end else begin
					want = pwm_results_q.pop_front();
					check_field("left_pwm", got.left_pwm, want.left_pwm);
					check_field("right_pwm", got.right_pwm, want.right_pwm);
					check_field("drive_lines", got.drive_lines, want.drive_lines);
					check_field("brake_lines", got.brake_lines, want.brake_lines);
					check_field("busy_res", got.busy_res, want.busy_res);
					check_field("done_res", got.done_res, want.done_res);
					check_field("band_mode", got.band_mode, want.band_mode);
					check_field("count_gap", got.count_gap, want.count_gap);
				end
			end
			if (items.valid && items.ready) begin
				it.kind          = items.kind;
				it.target_pulses = items.target_pulses;
				it.base_speed    = items.base_speed;
				it.move_type     = items.move_type;
				it.left_pulse    = items.left_pulse;
				it.right_pulse   = items.right_pulse;
				pwm_results_q.push_back(step_controller(it));
			end
			in_flight <= pwm_results_q.size();
		end
	end

endmodule

/* bench/encoder_balanced_drive_control_tb.sv */
// testbench top: clock, reset, limit settings and move stimulus for the drive controller
module encoder_balanced_drive_control_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ebdc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    fail_count;
	int                    in_flight;
	int unsigned           cycles = 0;

	bit no_idle  = 1'b0;
	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;

	int goal_pulses = 0;
	int left_sum    = 0;
	int right_sum   = 0;
	bit moving      = 1'b0;
	int work_items  = 0;

	int pulse_rates [5] = '{0, 20, 50, 80, 100};
	int max_set [7]     = '{240, 255, 0, 100, 255, 0, 180};
	int min_set [7]     = '{0, 0, 0, 120, 255, 0, 30};

	ebdc_in_if  items_ch ();
	ebdc_out_if results_ch ();

	encoder_balanced_drive_control u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	ebdc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items_ch),
		.results    (results_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.in_flight  (in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic push_item(input item_t it);
		int gap;
		items_ch.valid         <= 1'b1;
		items_ch.kind          <= it.kind;
		items_ch.target_pulses <= it.target_pulses;
		items_ch.base_speed    <= it.base_speed;
		items_ch.move_type     <= it.move_type;
		items_ch.left_pulse    <= it.left_pulse;
		items_ch.right_pulse   <= it.right_pulse;
		do
			@(posedge clk);
		while (!items_ch.ready);
		gap = (no_idle || tx_quiet) ? 0 : idle_len();
		if (gap != 0) begin
			items_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_start(input int tgt, input int spd, input int mtype);
		item_t it;
		it.kind          = KIND_START;
		it.target_pulses = TARGET_W'(tgt);
		it.base_speed    = SPEED_W'(spd);
		it.move_type     = 3'(mtype);
		it.left_pulse    = 1'($urandom_range(0, 1));
		it.right_pulse   = 1'($urandom_range(0, 1));
		goal_pulses = tgt;
		left_sum    = 0;
		right_sum   = 0;
		moving      = 1'b1;
		work_items++;
		push_item(it);
	endtask

	task automatic push_tick(input bit lp, input bit rp);
		item_t it;
		it.kind          = KIND_TICK;
		it.target_pulses = TARGET_W'($urandom_range(0, 32767));
		it.base_speed    = SPEED_W'($urandom_range(0, 255));
		it.move_type     = 3'($urandom_range(0, 7));
		it.left_pulse    = lp;
		it.right_pulse   = rp;
		if (moving) begin
			left_sum  += lp;
			right_sum += rp;
			work_items++;
			if (left_sum >= goal_pulses && right_sum >= goal_pulses)
				moving = 1'b0;
		end
		push_item(it);
	endtask

	task automatic drain();
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input int max_v, input int min_v);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_PWM;
		cfg_wdata <= CFG_DATA_W'(max_v);
		@(posedge clk);
		cfg_index <= CFG_MIN_PWM;
		cfg_wdata <= CFG_DATA_W'(min_v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls with quiet stretches
	initial begin
		int stall;
		stall = 0;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				rx_quiet = !rx_quiet;
			if (no_idle || rx_quiet) begin
				results_ch.ready <= 1'b1;
			end else if (stall > 0) begin
				results_ch.ready <= 1'b0;
				stall--;
			end else begin
				stall = idle_len();
				results_ch.ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		int ph;
		int quota;
		int sel;
		int tr;
		int tgt;
		int spd;
		int k;
		int n;
		int pl;
		int pr;
		bit broken;
		items_ch.valid         <= 1'b0;
		items_ch.kind          <= KIND_TICK;
		items_ch.target_pulses <= '0;
		items_ch.base_speed    <= '0;
		items_ch.move_type     <= '0;
		items_ch.left_pulse    <= 1'b0;
		items_ch.right_pulse   <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_MAX_PWM;
		cfg_wdata              <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero target, idle tick, restart while busy, every move type
		push_start(0, 0, MOVE_STRAIGHT);
		push_tick(1, 1);
		push_tick(1, 0);
		push_start(32767, 255, MOVE_BACK);
		push_tick(1, 1);
		push_start(6, 69, MOVE_ROT_CW);
		push_tick(1, 0);
		push_tick(1, 0);
		push_tick(0, 1);
		push_tick(1, 1);
		push_tick(1, 1);
		push_tick(1, 1);
		push_tick(0, 1);
		push_tick(0, 1);
		push_start(3, 70, MOVE_ROT_CC);
		push_tick(0, 0);
		push_start(3, 255, 0);
		push_tick(1, 1);
		push_start(2, 1, 5);
		push_tick(0, 1);
		push_start(2, 128, 6);
		push_tick(1, 0);
		push_start(1, 9, 7);
		push_tick(1, 1);

		for (ph = 0; ph < 7; ph++) begin
			drain();
			if (ph == 5)
				set_limits($urandom_range(0, 255), $urandom_range(0, 255));
			else
				set_limits(max_set[ph], min_set[ph]);
			quota = work_items + 175;
			while (work_items < quota) begin
				tx_quiet = ($urandom_range(0, 99) < 15);
				sel = $urandom_range(0, 99);
				if (sel < 8) begin
					repeat ($urandom_range(1, 3))
						push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end else begin
					tr = $urandom_range(0, 99);
					if (tr < 65)
						tgt = $urandom_range(0, 40);
					else if (tr < 92)
						tgt = $urandom_range(41, 150);
					else
						tgt = $urandom_range(0, 32767);
					tr = $urandom_range(0, 99);
					if (tr < 20)
						spd = $urandom_range(0, 12);
					else if (tr < 45)
						spd = $urandom_range(60, 80);
					else if (tr < 60)
						spd = $urandom_range(240, 255);
					else
						spd = $urandom_range(0, 255);
					push_start(tgt, spd, $urandom_range(0, 7));
					pl = pulse_rates[$urandom_range(0, 4)];
					pr = pulse_rates[$urandom_range(0, 4)];
					broken = ($urandom_range(0, 99) < 10) || (tgt > 150);
					n = broken ? $urandom_range(0, 30) : 2 * tgt + 20;
					for (k = 0; k < n && moving; k++)
						push_tick($urandom_range(0, 99) < pl, $urandom_range(0, 99) < pr);
					if (!broken)
						while (moving)
							push_tick(left_sum < goal_pulses, right_sum < goal_pulses);
					if ($urandom_range(0, 99) < 15)
						push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 99) < 3)
					drain();
			end
		end

		// long one-sided runs, both signs
		drain();
		tx_quiet = 1'b0;
		no_idle = 1'b1;
		push_start(32767, 10, MOVE_STRAIGHT);
		repeat (40) push_tick(1, 0);
		push_tick(0, 1);
		push_start(32767, 200, MOVE_ROT_CC);
		repeat (40) push_tick(0, 1);
		no_idle = 1'b0;
		push_start(2, 50, MOVE_BACK);
		push_tick(1, 1);
		push_tick(1, 1);

		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && in_flight == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
